### src/yaw_lp_pkg.sv
// Package for the yaw line parser: character codes, token and parse types.
// No dependencies; the parser modules, the checker and the testbench import it.
`default_nettype none

package yaw_lp_pkg;

    localparam int LINE_MAX = 25;
    localparam int CNT_W    = $clog2(LINE_MAX + 1);
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int NUM_FIELDS = 3;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [1:0]         FIELD_DONE     = 2'd3;
    localparam logic signed [32:0] HEADING_OFFSET = 33'sd18000;
    localparam logic signed [31:0] HEADING_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] HEADING_MIN    = 32'sh8000_4650;

    typedef enum logic [1:0] {
        TOK_CHAR,
        TOK_EOL,
        TOK_ABORT
    } tok_kind_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_NUL,
        CLS_OTHER
    } char_cls_t;

    typedef enum logic [1:0] {
        SUB_SKIP,
        SUB_SIGN,
        SUB_DIGITS,
        SUB_STOP
    } sub_phase_t;

    typedef struct packed {
        tok_kind_t  kind;
        char_cls_t  cls;
        logic [3:0] digit;
    } tok_t;

endpackage

`default_nettype wire

### src/yaw_lp_in_if.sv
// Input channel of the yaw line parser: one received character per item.
// Depends on nothing.
`default_nettype none

interface yaw_lp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/yaw_lp_out_if.sv
// Result channel of the yaw line parser: one item per parsed line.
// Depends on nothing.
`default_nettype none

interface yaw_lp_out_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic [1:0]         fields_matched;
    logic signed [31:0] heading_centi;
    logic               led_state;

    modport source (output valid, output checksum_ok, output fields_matched,
                    output heading_centi, output led_state, input ready);
    modport sink   (input valid, input checksum_ok, input fields_matched,
                    input heading_centi, input led_state, output ready);
endinterface

`default_nettype wire

### src/yaw_line_parser_core.sv
// Yaw line parser top level: front end, token queue, parser back end.
// Depends on yaw_lp_pkg, yaw_lp_in_if, yaw_lp_out_if and the yaw_lp_* modules.
// Throughput: one character per cycle while results are taken.
// A newline's token goes through the token queue, then the held fields, then the result register.
// A four-entry token queue lets the front end run on while the result waits.
// Reset (rst_n low, asynchronous) clears held fields, heading and LED to zero.
`default_nettype none

module yaw_line_parser_core
    import yaw_lp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    yaw_lp_in_if.sink     rx,
    yaw_lp_out_if.source  res
);

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_head_valid;
    tok_t    push_tok;
    tok_t    head_tok;

    yaw_lp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .q_push (q_push),
        .q_tok  (push_tok)
    );

    yaw_lp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_tok   (push_tok),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_tok   (head_tok)
    );

    yaw_lp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_head_valid),
        .q_tok   (head_tok),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

`default_nettype wire

### src/yaw_lp_front.sv
// Front end: counts line length, drops overlong lines, classifies characters.
// Depends on yaw_lp_pkg and yaw_lp_in_if.
`default_nettype none

module yaw_lp_front
    import yaw_lp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    yaw_lp_in_if.sink     rx,
    input  wire logic     q_full,
    output logic          q_push,
    output tok_t          q_tok
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             accept;
    char_cls_t        cls;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        if (rx.rx_byte == CH_NUL)
            cls = CLS_NUL;
        else if (rx.rx_byte == CH_SPACE || rx.rx_byte inside {[CH_TAB:CH_CR]})
            cls = CLS_SPACE;
        else if (rx.rx_byte == CH_PLUS)
            cls = CLS_PLUS;
        else if (rx.rx_byte == CH_MINUS)
            cls = CLS_MINUS;
        else if (rx.rx_byte inside {[CH_ZERO:CH_NINE]})
            cls = CLS_DIGIT;
        else
            cls = CLS_OTHER;
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        q_push       = 1'b0;
        q_tok.kind   = TOK_CHAR;
        q_tok.cls    = cls;
        q_tok.digit  = rx.rx_byte[3:0];
        if (accept)
        begin
            if (rx.rx_byte == CH_NL)
            begin
                q_push       = 1'b1;
                q_tok.kind   = dropped_reg ? TOK_ABORT : TOK_EOL;
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else if (!dropped_reg)
            begin
                if (count_reg == CNT_W'(LINE_MAX))
                    dropped_next = 1'b1;
                else
                begin
                    count_next = count_reg + 1'b1;
                    q_push     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

`default_nettype wire

### src/yaw_lp_queue.sv
// Short token queue between the front end and the parser back end.
// Depends on yaw_lp_pkg.
`default_nettype none

module yaw_lp_queue
    import yaw_lp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  tok_t      push_tok,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output tok_t      head_tok
);

    tok_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = cnt_reg == QCNT_W'(QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_tok   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### src/yaw_lp_back.sv
// Back end: scanf-style field parser, line commit, checksum, heading and result register.
// Depends on yaw_lp_pkg and yaw_lp_out_if.
`default_nettype none

module yaw_lp_back
    import yaw_lp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_valid,
    input  tok_t          q_tok,
    output logic          q_pop,
    yaw_lp_out_if.source  res
);

    sub_phase_t  sub_reg, sub_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [31:0] pend_reg [NUM_FIELDS];
    logic [31:0] pend_next [NUM_FIELDS];
    logic [31:0] header_reg, header_next;
    logic [31:0] yaw_reg, yaw_next;
    logic [31:0] check_reg, check_next;
    logic        done_reg, done_next;
    logic [1:0]  matched_reg, matched_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [1:0]         out_matched_reg, out_matched_next;
    logic signed [31:0] heading_reg, heading_next;
    logic               led_reg, led_next;

    logic               finish;
    logic               commit;
    logic [31:0]        commit_val;
    logic [31:0]        acc_x10;
    logic [7:0]         sum_lo;
    logic               sum_ok;
    logic signed [32:0] head_wide;
    logic signed [31:0] head_sat;

    // Control: pop, commit and finish
    always_comb
    begin
        finish = done_reg && (!out_valid_reg || res.ready);
        q_pop  = q_valid && !(q_tok.kind == TOK_EOL && done_reg && !finish);
        commit = q_pop && idx_reg != FIELD_DONE && sub_reg == SUB_DIGITS
                 && (q_tok.kind == TOK_EOL
                     || (q_tok.kind == TOK_CHAR && q_tok.cls != CLS_DIGIT));
    end

    assign commit_val = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign acc_x10    = (acc_reg << 3) + (acc_reg << 1);

    // Parser next state
    always_comb
    begin
        sub_next     = sub_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        pend_next    = pend_reg;
        header_next  = header_reg;
        yaw_next     = yaw_reg;
        check_next   = check_reg;
        matched_next = matched_reg;
        done_next    = done_reg && !finish;

        if (commit)
        begin
            pend_next[idx_reg] = commit_val;
            idx_next           = idx_reg + 1'b1;
            acc_next           = '0;
            neg_next           = 1'b0;
            sub_next           = SUB_SKIP;
        end

        if (q_pop)
        begin
            case (q_tok.kind)
                TOK_CHAR:
                begin
                    if (idx_reg != FIELD_DONE && sub_reg != SUB_STOP)
                    begin
                        if (q_tok.cls == CLS_NUL)
                            sub_next = SUB_STOP;
                        else if (sub_reg == SUB_SKIP || sub_reg == SUB_DIGITS)
                        begin
                            if (q_tok.cls == CLS_DIGIT)
                            begin
                                if (sub_reg == SUB_DIGITS)
                                    acc_next = acc_x10 + {28'd0, q_tok.digit};
                                else
                                begin
                                    acc_next = {28'd0, q_tok.digit};
                                    sub_next = SUB_DIGITS;
                                end
                            end
                            else if (q_tok.cls == CLS_SPACE)
                                sub_next = SUB_SKIP;
                            else if (q_tok.cls == CLS_PLUS || q_tok.cls == CLS_MINUS)
                            begin
                                neg_next = q_tok.cls == CLS_MINUS;
                                sub_next = SUB_SIGN;
                            end
                            else
                                sub_next = SUB_STOP;
                        end
                        else
                        begin
                            if (q_tok.cls == CLS_DIGIT)
                            begin
                                acc_next = {28'd0, q_tok.digit};
                                sub_next = SUB_DIGITS;
                            end
                            else
                                sub_next = SUB_STOP;
                        end
                    end
                end
                TOK_EOL:
                begin
                    matched_next = idx_next;
                    if (idx_next != 2'd0)
                        header_next = pend_next[0];
                    if (idx_next > 2'd1)
                        yaw_next = pend_next[1];
                    if (idx_next > 2'd2)
                        check_next = pend_next[2];
                    done_next = 1'b1;
                    sub_next  = SUB_SKIP;
                    idx_next  = '0;
                    acc_next  = '0;
                    neg_next  = 1'b0;
                end
                TOK_ABORT:
                begin
                    sub_next = SUB_SKIP;
                    idx_next = '0;
                    acc_next = '0;
                    neg_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Result stage
    always_comb
    begin
        sum_lo    = header_reg[7:0] + yaw_reg[7:0] + check_reg[7:0];
        sum_ok    = sum_lo == 8'd0;
        head_wide = $signed({yaw_reg[31], yaw_reg}) + HEADING_OFFSET;
        head_sat  = (!head_wide[32] && head_wide[31]) ? HEADING_MAX : head_wide[31:0];

        out_valid_next   = out_valid_reg && !res.ready;
        out_ok_next      = out_ok_reg;
        out_matched_next = out_matched_reg;
        heading_next     = heading_reg;
        led_next         = led_reg;
        if (finish)
        begin
            out_valid_next   = 1'b1;
            out_ok_next      = sum_ok;
            out_matched_next = matched_reg;
            if (sum_ok)
            begin
                heading_next = head_sat;
                led_next     = !led_reg;
            end
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.checksum_ok    = out_ok_reg;
    assign res.fields_matched = out_matched_reg;
    assign res.heading_centi  = heading_reg;
    assign res.led_state      = led_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg         <= SUB_SKIP;
            idx_reg         <= '0;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            pend_reg        <= '{default: '0};
            header_reg      <= '0;
            yaw_reg         <= '0;
            check_reg       <= '0;
            done_reg        <= 1'b0;
            matched_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_ok_reg      <= 1'b0;
            out_matched_reg <= '0;
            heading_reg     <= '0;
            led_reg         <= 1'b0;
        end
        else
        begin
            sub_reg         <= sub_next;
            idx_reg         <= idx_next;
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            pend_reg        <= pend_next;
            header_reg      <= header_next;
            yaw_reg         <= yaw_next;
            check_reg       <= check_next;
            done_reg        <= done_next;
            matched_reg     <= matched_next;
            out_valid_reg   <= out_valid_next;
            out_ok_reg      <= out_ok_next;
            out_matched_reg <= out_matched_next;
            heading_reg     <= heading_next;
            led_reg         <= led_next;
        end
    end

endmodule

`default_nettype wire

### src/yaw_lp_checker.sv
// Port-level checker for the yaw line parser and its bind to the top level.
// Depends on yaw_lp_pkg and yaw_line_parser_core.
`default_nettype none

module yaw_lp_checker
    import yaw_lp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic               checksum_ok,
    input wire logic signed [31:0] heading_centi,
    input wire logic               led_state
);

    logic               last_led_reg;
    logic signed [31:0] last_heading_reg;
    logic               res_fire;

    assign res_fire = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_led_reg     <= 1'b0;
            last_heading_reg <= '0;
        end
        else if (res_fire)
        begin
            last_led_reg     <= led_state;
            last_heading_reg <= heading_centi;
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(heading_centi))
        else $error("result dropped or changed while stalled");

    a_bad_line_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && !checksum_ok |->
            led_state == last_led_reg && heading_centi == last_heading_reg)
        else $error("heading or LED changed on a failed checksum");

    a_good_line_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && checksum_ok |-> led_state != last_led_reg)
        else $error("LED did not toggle on a good checksum");

    a_heading_floor: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && checksum_ok |-> heading_centi >= HEADING_MIN)
        else $error("heading below yaw offset floor");

endmodule

bind yaw_line_parser_core yaw_lp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .checksum_ok   (res.checksum_ok),
    .heading_centi (res.heading_centi),
    .led_state     (res.led_state)
);

`default_nettype wire

### sim/yaw_line_parser_core_tb.sv
// Testbench for yaw_line_parser_core: sends received characters, predicts each line's result
// and checks every result item in order. Depends on yaw_lp_pkg, yaw_lp_in_if, yaw_lp_out_if
// and the parser RTL.
module yaw_line_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import yaw_lp_pkg::*;

    localparam logic [7:0] CH_VTAB = 8'd11;
    localparam logic [7:0] CH_FEED = 8'd12;
    localparam int RANDOM_CHARS = 750;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mode_t;

    typedef struct {
        logic               ok;
        logic [1:0]         matched;
        logic signed [31:0] heading;
        logic               led;
    } line_result_t;

    logic clk;
    logic rst_n;

    yaw_lp_in_if  rx_if ();
    yaw_lp_out_if res_if ();

    yaw_line_parser_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    line_result_t expected_lines[$];
    logic [7:0]   line_buf[$];
    idle_mode_t   tx_mode = IDLE_NONE;
    idle_mode_t   rx_mode = IDLE_NONE;
    int           fail_count = 0;
    int           parsed_chars = 0;
    int           quiet_cycles = 0;

    int                 line_len = 0;
    int                 field_no = 0;
    sub_phase_t         scan_step = SUB_SKIP;
    logic [31:0]        digits_acc = '0;
    logic               minus_seen = 1'b0;
    logic               line_dropped = 1'b0;
    logic [31:0]        pend_fields[NUM_FIELDS] = '{default: '0};
    logic [31:0]        header_held = '0;
    logic [31:0]        yaw_held = '0;
    logic [31:0]        check_held = '0;
    logic signed [31:0] heading_held = '0;
    logic               led_held = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_blank(logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic bit is_numeral(logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic void restart_line();
        line_len     = 0;
        field_no     = 0;
        scan_step    = SUB_SKIP;
        digits_acc   = '0;
        minus_seen   = 1'b0;
        line_dropped = 1'b0;
        pend_fields  = '{default: '0};
    endfunction

    function automatic void close_field();
        if (field_no < NUM_FIELDS)
            pend_fields[field_no] = minus_seen ? 32'd0 - digits_acc : digits_acc;
        field_no++;
        scan_step  = SUB_SKIP;
        digits_acc = '0;
        minus_seen = 1'b0;
    endfunction

    function automatic void scan_char(logic [7:0] ch);
        for (int attempt = 0; attempt < 2; attempt++)
        begin
            if (field_no >= NUM_FIELDS || scan_step == SUB_STOP)
                return;
            if (ch == CH_NUL)
            begin
                if (scan_step == SUB_DIGITS)
                    close_field();
                scan_step = SUB_STOP;
                return;
            end
            case (scan_step)
                SUB_SKIP:
                begin
                    if (is_blank(ch))
                        return;
                    if (ch == CH_PLUS || ch == CH_MINUS)
                    begin
                        minus_seen = (ch == CH_MINUS);
                        scan_step  = SUB_SIGN;
                    end
                    else if (is_numeral(ch))
                    begin
                        digits_acc = 32'(ch - CH_ZERO);
                        scan_step  = SUB_DIGITS;
                    end
                    else
                        scan_step = SUB_STOP;
                    return;
                end
                SUB_SIGN:
                begin
                    if (is_numeral(ch))
                    begin
                        digits_acc = 32'(ch - CH_ZERO);
                        scan_step  = SUB_DIGITS;
                    end
                    else
                        scan_step = SUB_STOP;
                    return;
                end
                default:
                begin
                    if (is_numeral(ch))
                    begin
                        digits_acc = digits_acc * 32'd10 + 32'(ch - CH_ZERO);
                        return;
                    end
                    close_field();
                end
            endcase
        end
    endfunction

    // Returns 1 when the character is not ignored by the parser.
    function automatic bit predict_rx_char(logic [7:0] ch);
        line_result_t       outcome;
        logic [31:0]        total;
        logic signed [32:0] lifted;
        int                 matched;
        if (ch != CH_NL)
        begin
            if (line_dropped)
                return 1'b0;
            if (line_len >= LINE_MAX)
            begin
                line_dropped = 1'b1;
                return 1'b0;
            end
            line_len++;
            scan_char(ch);
            return 1'b1;
        end
        if (line_dropped)
        begin
            restart_line();
            return 1'b1;
        end
        if (field_no < NUM_FIELDS && scan_step == SUB_DIGITS)
            close_field();
        matched = (field_no > NUM_FIELDS) ? NUM_FIELDS : field_no;
        if (matched > 0)
            header_held = pend_fields[0];
        if (matched > 1)
            yaw_held = pend_fields[1];
        if (matched > 2)
            check_held = pend_fields[2];
        total = header_held + yaw_held + check_held;
        outcome.ok = (total[7:0] == 8'd0);
        if (outcome.ok)
        begin
            lifted       = $signed({yaw_held[31], yaw_held}) + HEADING_OFFSET;
            heading_held = (lifted > HEADING_MAX) ? HEADING_MAX : lifted[31:0];
            led_held     = ~led_held;
        end
        restart_line();
        outcome.matched = matched[1:0];
        outcome.heading = heading_held;
        outcome.led     = led_held;
        expected_lines.push_back(outcome);
        return 1'b1;
    endfunction

    function automatic int pick_gap(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 16);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 7))
            4:       return CH_TAB;
            5:       return CH_CR;
            6:       return CH_VTAB;
            7:       return CH_FEED;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_blanks(int n);
        repeat (n) line_buf.push_back(pick_blank());
    endfunction

    function automatic void put_number(logic [31:0] v, bit signed_field);
        if (signed_field ? v[31] : ($urandom_range(0, 9) == 0))
        begin
            line_buf.push_back(CH_MINUS);
            put_text($sformatf("%0d", 32'd0 - v));
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                line_buf.push_back(CH_PLUS);
            put_text($sformatf("%0d", v));
        end
    endfunction

    function automatic void put_digit_run(int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = pick_gap(tx_mode);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= ch;
        @(negedge clk);
        while (!rx_if.ready)
            @(negedge clk);
        @(posedge clk);
        if (predict_rx_char(ch))
            parsed_chars++;
    endtask

    task automatic send_buf();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic send_line(string s);
        put_text(s);
        line_buf.push_back(CH_NL);
        send_buf();
    endtask

    task automatic hold_until_drained();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_lines.size() != 0)
            @(posedge clk);
    endtask

    function automatic void build_random_line();
        int          kind;
        int          nf;
        int          target;
        logic [31:0] hdr;
        logic [31:0] yaw;
        logic [31:0] chk;
        logic [7:0]  b;
        kind = $urandom_range(0, 19);
        hdr  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 999);
        case ($urandom_range(0, 9))
            0:       yaw = 32'h7FFF_FFFF;
            1:       yaw = 32'h8000_0000;
            2:       yaw = $urandom;
            default: yaw = 32'($urandom_range(0, 72000)) - 32'd36000;
        endcase
        if ($urandom_range(0, 3) != 0)
            chk = ((32'd0 - hdr - yaw) & 32'hFF) + 32'd256 * $urandom_range(0, 3);
        else
            chk = $urandom_range(0, 999);
        if (kind < 13)
        begin
            nf = (kind < 11) ? 3 : $urandom_range(1, 2);
            put_blanks($urandom_range(0, 2));
            put_number(hdr, 1'b0);
            if (nf > 1)
            begin
                put_blanks($urandom_range(0, 2));
                put_number(yaw, 1'b1);
            end
            if (nf > 2)
            begin
                put_blanks($urandom_range(0, 2));
                put_number(chk, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                put_blanks($urandom_range(1, 3));
        end
        else if (kind < 16)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    put_number(hdr, 1'b0);
                    put_blanks($urandom_range(1, 2));
                    line_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                    put_blanks($urandom_range(0, 1));
                    put_text("7 1");
                end
                1:
                begin
                    put_digit_run($urandom_range(0, 3));
                    put_blanks($urandom_range(0, 1));
                    put_digit_run($urandom_range(0, 3));
                    line_buf.push_back(CH_NUL);
                    put_text(" 8 1");
                end
                2:
                begin
                    put_number(hdr, 1'b0);
                    line_buf.push_back(8'($urandom_range(33, 126)));
                    put_text(" 4 4");
                end
                default:
                begin
                    put_digit_run($urandom_range(11, 15));
                    put_blanks(1);
                    put_number(yaw, 1'b1);
                    put_text(" 0");
                end
            endcase
        end
        else if (kind < 18)
        begin
            repeat ($urandom_range(0, 30))
            begin
                b = $urandom_range(0, 255);
                line_buf.push_back((b == CH_NL) ? ~CH_NL : b);
            end
        end
        else
        begin
            put_text("1 2 253");
            target = $urandom_range(LINE_MAX + 1, LINE_MAX + 9);
            while (line_buf.size() < target)
                line_buf.push_back(pick_blank());
        end
        line_buf.push_back(CH_NL);
    endfunction

    task automatic test_field_extremes();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        send_line("0 0 0");
        send_line("4294967295 1 0");
        send_line("255 2147483647 2");
        send_line("0 -2147483648 0");
        send_line("99999999999 1 0");
        send_line("+5 -5 0");
    endtask

    task automatic test_separators();
        tx_mode = IDLE_SPARSE;
        rx_mode = IDLE_SPARSE;
        send_line("12-5+3");
        line_buf.push_back(CH_TAB);
        put_text("9");
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_VTAB);
        put_text("-9");
        line_buf.push_back(CH_FEED);
        put_text("0");
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(CH_NL);
        send_buf();
        send_line("");
        send_line("   ");
    endtask

    task automatic test_mismatch_rules();
        tx_mode = IDLE_FULL;
        rx_mode = IDLE_FULL;
        send_line("7 -x 3");
        send_line("abc");
        put_text("3 4");
        line_buf.push_back(CH_NUL);
        put_text("9");
        line_buf.push_back(CH_NL);
        send_buf();
        line_buf.push_back(CH_NUL);
        send_line("5 5 5");
        put_text("1");
        line_buf.push_back(8'hFF);
        send_line(" 2 3");
    endtask

    task automatic test_long_lines();
        tx_mode = IDLE_SPARSE;
        rx_mode = IDLE_FULL;
        put_text("1 2 253");
        while (line_buf.size() < LINE_MAX)
            line_buf.push_back(CH_SPACE);
        line_buf.push_back(CH_NL);
        send_buf();
        put_text("8 8 8");
        while (line_buf.size() < LINE_MAX + 6)
            line_buf.push_back(CH_SPACE);
        line_buf.push_back(CH_NL);
        send_buf();
        send_line("3");
    endtask

    task automatic test_drained_lines();
        tx_mode = IDLE_FULL;
        rx_mode = IDLE_FULL;
        repeat (6)
        begin
            build_random_line();
            send_buf();
            hold_until_drained();
        end
    endtask

    task automatic test_random_lines();
        parsed_chars = 0;
        while (parsed_chars < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                tx_mode = idle_mode_t'($urandom_range(0, 2));
                rx_mode = idle_mode_t'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 59) == 0)
                hold_until_drained();
            build_random_line();
            send_buf();
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap(rx_mode);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(negedge clk);
            while (!res_if.valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    always @(negedge clk)
    begin : result_check
        line_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_lines.size() == 0)
            begin
                $error("result item with no line pending");
                fail_count++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (res_if.checksum_ok !== want.ok)
                begin
                    $error("checksum_ok: expected %0d, got %0d", want.ok, res_if.checksum_ok);
                    fail_count++;
                end
                if (res_if.fields_matched !== want.matched)
                begin
                    $error("fields_matched: expected %0d, got %0d",
                           want.matched, res_if.fields_matched);
                    fail_count++;
                end
                if (res_if.heading_centi !== want.heading)
                begin
                    $error("heading_centi: expected %0d, got %0d",
                           want.heading, res_if.heading_centi);
                    fail_count++;
                end
                if (res_if.led_state !== want.led)
                begin
                    $error("led_state: expected %0d, got %0d", want.led, res_if.led_state);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_field_extremes();
        test_separators();
        test_mismatch_rules();
        test_long_lines();
        test_drained_lines();
        test_random_lines();
        rx_if.valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### yaw_line_parser_core.f
src/yaw_lp_pkg.sv
src/yaw_lp_in_if.sv
src/yaw_lp_out_if.sv
src/yaw_lp_front.sv
src/yaw_lp_queue.sv
src/yaw_lp_back.sv
src/yaw_line_parser_core.sv
src/yaw_lp_checker.sv
sim/yaw_line_parser_core_tb.sv
